FILE: design/quadratic_root_solver_top_macros.svh
// Assertion macros for the quadratic root solver.
// Used by the modules in this folder that carry assertions.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QRS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRS_ASSERT(label, clk, rst_n, prop, msg)
`define QRS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: design/qrs_pkg.sv
// Package for the quadratic root solver: result status codes.
// No dependencies.
`timescale 1ns / 1ps
package qrs_pkg;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOT = 2'd1;
    localparam logic [1:0] ST_AZERO  = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;
endpackage

FILE: design/qrs_sqrt_cell.sv
// One cell of the pipelined square root: settles one result bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module qrs_sqrt_cell #(
    parameter int RW  = 66,
    parameter int SW  = 33,
    parameter int POS = 0
) (
    input  logic          clk,
    input  logic [RW-1:0] rem_in,
    input  logic [SW-1:0] root_in,
    output logic [RW-1:0] rem_out,
    output logic [SW-1:0] root_out
);
    logic [RW-1:0] trial;
    logic          take;
    logic [RW-1:0] rem_next;
    logic [SW-1:0] root_next;
    logic [RW-1:0] rem_reg;
    logic [SW-1:0] root_reg;

    // trial = (4*root + 1) << 2*POS, the growth of the square when this bit is set
    always_comb
    begin
        trial     = ((RW'(root_in) << 2) | RW'(1)) << (2*POS);
        take      = rem_in >= trial;
        rem_next  = take ? rem_in - trial : rem_in;
        root_next = {root_in[SW-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

FILE: design/qrs_div_cell.sv
// One cell of the pipelined restoring divider: settles one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module qrs_div_cell #(
    parameter int NW  = 64,
    parameter int DW  = 34,
    parameter int POS = 0
) (
    input  logic          clk,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    input  logic [NW-1:0] quo_in,
    output logic [NW-1:0] num_out,
    output logic [DW-1:0] den_out,
    output logic [NW-1:0] quo_out
);
    logic [NW+DW-1:0] shifted;
    logic             take;
    logic [NW-1:0]    num_next;
    logic [NW-1:0]    quo_next;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [NW-1:0]    quo_reg;

    // num_in holds the running remainder; test den << POS against it
    always_comb
    begin
        shifted  = (NW+DW)'(den_in) << POS;
        take     = (den_in != '0) && ((NW+DW)'(num_in) >= shifted);
        num_next = take ? num_in - NW'(shifted) : num_in;
        quo_next = quo_in | (NW'(take) << POS);
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_in;
        quo_reg <= quo_next;
    end

    assign num_out = num_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
endmodule

FILE: design/quadratic_root_solver_top.sv
// Quadratic root solver (W = WORD_BITS, F = FRACTION_BITS): four front stages, W+1 square
// root cells, a setup stage, W+F+3 divider cells and the output register.
// Throughput one item per cycle; an output stall freezes the whole row and is passed back.
// Reset clears only the valid bits of every stage; payload registers are not reset.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell and the macro header.
`timescale 1ns / 1ps
`include "quadratic_root_solver_top_macros.svh"
module quadratic_root_solver_top
    import qrs_pkg::*;
#(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WORD_BITS-1:0] coef_a,
    input  logic signed [WORD_BITS-1:0] coef_b,
    input  logic signed [WORD_BITS-1:0] coef_c,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic signed [WORD_BITS-1:0] root_one,
    output logic signed [WORD_BITS-1:0] root_two
);
    localparam int W   = WORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int PW  = 2*W;          // product width
    localparam int DW  = 2*W + 2;      // discriminant width
    localparam int SQ  = W + 1;        // sqrt width
    localparam int QW  = W + 2;        // |b|+sqrt width
    localparam int NW  = QW + F + 1;   // numerator width (covers both divisions)
    localparam int NSQ = SQ;           // sqrt cells
    localparam int NDV = NW;           // divider cells
    localparam int LAT = 4 + NSQ + 1 + NDV + 1;

    // Stalling freezes the whole pipeline; output stays valid while stalled.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // sideband carried along the whole chain
    typedef struct packed {
        logic         azero;
        logic         noroot;
        logic         dzero;
        logic         na;
        logic         nb;
        logic         nc;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] mc;
    } side_t;

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end
    assign out_valid = vld_reg[LAT-1];

    // stage 1: magnitudes
    side_t s1_next, s1_reg;
    always_comb
    begin
        s1_next    = '0;
        s1_next.na = coef_a[W-1];
        s1_next.nb = coef_b[W-1];
        s1_next.nc = coef_c[W-1];
        s1_next.ma = coef_a[W-1] ? W'(-coef_a) : coef_a;
        s1_next.mb = coef_b[W-1] ? W'(-coef_b) : coef_b;
        s1_next.mc = coef_c[W-1] ? W'(-coef_c) : coef_c;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_reg <= s1_next;
    end

    // stage 2: products
    side_t         s2_next, s2_reg;
    logic [PW-1:0] bb_reg, ac_reg;
    always_comb
    begin
        s2_next       = s1_reg;
        s2_next.azero = s1_reg.ma == '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s2_next;
            bb_reg <= PW'(s1_reg.mb) * PW'(s1_reg.mb);
            ac_reg <= PW'(s1_reg.ma) * PW'(s1_reg.mc);
        end
    end

    // stage 3: discriminant
    side_t         s3_next, s3_reg;
    logic [DW-1:0] disc_next, disc_reg;
    logic [DW-1:0] bbx, acx;
    assign bbx = DW'(bb_reg);
    assign acx = DW'(ac_reg) << 2;
    always_comb
    begin
        s3_next = s2_reg;
        if (s2_reg.na != s2_reg.nc)
            disc_next = bbx + acx;
        else if (acx > bbx)
        begin
            disc_next      = '0;
            s3_next.noroot = 1'b1;
        end
        else
            disc_next = bbx - acx;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg   <= s3_next;
            disc_reg <= disc_next;
        end
    end

    // stage 4: flag zero discriminant
    side_t         s4_next, s4_reg;
    logic [DW-1:0] disc4_reg;
    always_comb
    begin
        s4_next       = s3_reg;
        s4_next.dzero = disc_reg == '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg    <= s4_next;
            disc4_reg <= disc_reg;
        end
    end

    // square root row: cell k settles root bit NSQ-1-k
    logic [DW-1:0] sq_rem  [NSQ+1];
    logic [SQ-1:0] sq_root [NSQ+1];
    side_t         sq_side [NSQ+1];
    assign sq_rem[0]  = disc4_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = s4_reg;

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        logic [DW-1:0] rem_o;
        logic [SQ-1:0] root_o;
        qrs_sqrt_cell #(.RW(DW), .SW(SQ), .POS(NSQ-1-k)) u_cell (
            .clk      (clk),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rem_out  (rem_o),
            .root_out (root_o)
        );
        // hold behavior: cells are transparent registers; gate by adv through mux
        logic [DW-1:0] rem_h_reg;
        logic [SQ-1:0] root_h_reg;
        side_t         side_reg;
        logic          adv_d_reg;
        always_ff @(posedge clk)
        begin
            adv_d_reg <= adv;
            if (adv_d_reg)
            begin
                rem_h_reg  <= rem_o;
                root_h_reg <= root_o;
            end
            if (adv)
                side_reg <= sq_side[k];
        end
        assign sq_rem[k+1]  = adv_d_reg ? rem_o : rem_h_reg;
        assign sq_root[k+1] = adv_d_reg ? root_o : root_h_reg;
        assign sq_side[k+1] = side_reg;
    end

    // setup stage: pick numerators and divisors for both quotients
    // root one: num = |q2| << F, den = 2|a|; root two: num = |c| << F+1, den = q2
    // zero discriminant: root one num = |b| << F, den = 2|a|
    side_t         s5_reg;
    logic [NW-1:0] n1_reg, n2_reg;
    logic [QW-1:0] d1_reg, d2_reg;
    logic          nq_reg;
    side_t         s5_in;
    logic [QW-1:0] q2;
    assign s5_in = sq_side[NSQ];
    assign q2    = QW'(s5_in.mb) + QW'(sq_root[NSQ]);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_reg <= s5_in;
            d1_reg <= QW'(s5_in.ma) << 1;
            if (s5_in.dzero)
            begin
                n1_reg <= NW'(s5_in.mb) << F;
                n2_reg <= '0;
                d2_reg <= '0;
                nq_reg <= !s5_in.nb;
            end
            else
            begin
                n1_reg <= NW'(q2) << F;
                n2_reg <= NW'(s5_in.mc) << (F+1);
                d2_reg <= q2;
                nq_reg <= !s5_in.nb && (s5_in.mb != '0);
            end
        end
    end

    // divider rows: cell k settles quotient bit NDV-1-k
    logic [NW-1:0] d1n [NDV+1];
    logic [QW-1:0] d1d [NDV+1];
    logic [NW-1:0] d1q [NDV+1];
    logic [NW-1:0] d2n [NDV+1];
    logic [QW-1:0] d2d [NDV+1];
    logic [NW-1:0] d2q [NDV+1];
    side_t         dvs [NDV+1];
    logic          dnq [NDV+1];
    assign d1n[0] = n1_reg;
    assign d1d[0] = d1_reg;
    assign d1q[0] = '0;
    assign d2n[0] = n2_reg;
    assign d2d[0] = d2_reg;
    assign d2q[0] = '0;
    assign dvs[0] = s5_reg;
    assign dnq[0] = nq_reg;

    for (genvar k = 0; k < NDV; k++)
    begin : g_div
        logic [NW-1:0] n1o, q1o, n2o, q2o;
        logic [QW-1:0] e1o, e2o;
        qrs_div_cell #(.NW(NW), .DW(QW), .POS(NDV-1-k)) u_one (
            .clk (clk), .num_in (d1n[k]), .den_in (d1d[k]), .quo_in (d1q[k]),
            .num_out (n1o), .den_out (e1o), .quo_out (q1o)
        );
        qrs_div_cell #(.NW(NW), .DW(QW), .POS(NDV-1-k)) u_two (
            .clk (clk), .num_in (d2n[k]), .den_in (d2d[k]), .quo_in (d2q[k]),
            .num_out (n2o), .den_out (e2o), .quo_out (q2o)
        );
        logic          adv_d_reg;
        logic [NW-1:0] h1n_reg, h1q_reg, h2n_reg, h2q_reg;
        logic [QW-1:0] h1d_reg, h2d_reg;
        side_t         side_reg;
        logic          nq_k_reg;
        always_ff @(posedge clk)
        begin
            adv_d_reg <= adv;
            if (adv_d_reg)
            begin
                h1n_reg <= n1o;
                h1d_reg <= e1o;
                h1q_reg <= q1o;
                h2n_reg <= n2o;
                h2d_reg <= e2o;
                h2q_reg <= q2o;
            end
            if (adv)
            begin
                side_reg <= dvs[k];
                nq_k_reg <= dnq[k];
            end
        end
        assign d1n[k+1] = adv_d_reg ? n1o : h1n_reg;
        assign d1d[k+1] = adv_d_reg ? e1o : h1d_reg;
        assign d1q[k+1] = adv_d_reg ? q1o : h1q_reg;
        assign d2n[k+1] = adv_d_reg ? n2o : h2n_reg;
        assign d2d[k+1] = adv_d_reg ? e2o : h2d_reg;
        assign d2q[k+1] = adv_d_reg ? q2o : h2q_reg;
        assign dvs[k+1] = side_reg;
        assign dnq[k+1] = nq_k_reg;
    end

    // pack and saturate
    side_t         fs;
    logic          fnq;
    logic [NW-1:0] m1, m2;
    logic          neg1, neg2, sat1, sat2;
    logic [W-1:0]  v1, v2;
    logic [W-1:0]  half;
    assign fs   = dvs[NDV];
    assign fnq  = dnq[NDV];
    assign m1   = d1q[NDV];
    assign m2   = fs.dzero ? d1q[NDV] : d2q[NDV];
    assign half = W'(1) << (W-1);
    assign neg1 = fnq != fs.na;
    assign neg2 = fs.dzero ? neg1 : (fs.nc != fnq);
    assign sat1 = m1 > NW'(neg1 ? half : half - W'(1));
    assign sat2 = m2 > NW'(neg2 ? half : half - W'(1));
    always_comb
    begin
        v1 = sat1 ? (neg1 ? half : half - W'(1)) : W'(m1);
        v2 = sat2 ? (neg2 ? half : half - W'(1)) : W'(m2);
        if (neg1)
            v1 = W'(-v1);
        if (neg2)
            v2 = W'(-v2);
    end

    logic [1:0]   st_reg;
    logic [W-1:0] r1_reg, r2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (fs.azero)
            begin
                st_reg <= ST_AZERO;
                r1_reg <= '0;
                r2_reg <= '0;
            end
            else if (fs.noroot)
            begin
                st_reg <= ST_NOROOT;
                r1_reg <= '0;
                r2_reg <= '0;
            end
            else
            begin
                st_reg <= (sat1 || sat2) ? ST_SAT : ST_OK;
                r1_reg <= v1;
                r2_reg <= v2;
            end
        end
    end

    assign status   = st_reg;
    assign root_one = r1_reg;
    assign root_two = r2_reg;

    `QRS_ASSERT(a_stall_out, clk, rst_n, (out_valid && out_stall) |-> in_stall, "stall not passed back")
    `QRS_ASSERT(a_hold, clk, rst_n, (out_valid && out_stall) |=> $stable(root_one) && $stable(status), "output moved under stall")
    `QRS_ASSERT(a_zero_roots, clk, rst_n, (out_valid && (status == ST_AZERO || status == ST_NOROOT)) |-> (root_one == '0 && root_two == '0), "nonzero root with no-root status")
    `QRS_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid || !rst_n, "valid out of reset")
endmodule
